// File: rtl/core/sensor_mailbox_range_tagger_defines.svh
// assertion helpers for the sensor mailbox
`ifndef SENSOR_MAILBOX_RANGE_TAGGER_DEFINES_SVH
`define SENSOR_MAILBOX_RANGE_TAGGER_DEFINES_SVH

// same-cycle implication
`define SMRT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smrt: same-cycle check failed");

// next-cycle implication
`define SMRT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smrt: next-cycle check failed");

`endif

// File: rtl/core/smrt_pkg.sv
`default_nettype none
package smrt_pkg;

  localparam int NUM_SLOTS     = 5;
  localparam int SLOT_IDX_W    = $clog2(NUM_SLOTS);
  localparam int SLOT_CNT_W    = $clog2(NUM_SLOTS + 1);
  localparam int KIND_W        = 3;
  localparam int REQ_W         = 3;
  localparam int SRC_W         = 2;
  localparam int FRAME_ID_W    = 16;
  localparam int FRAME_RANGE_W = 32;
  localparam int BOUND_W       = 31;
  localparam int FALLBACK_W    = 16;
  localparam int CFG_DATA_W    = 31;
  localparam int CFG_IDX_W     = 2;

  localparam logic [KIND_W-1:0] KIND_EMPTY = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SPEED = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ATT   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ALT   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RANGE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_FRAME = 3'd5;
  localparam logic [KIND_W-1:0] KIND_NULL  = 3'd6;

  localparam logic [REQ_W-1:0] REQ_PUSH_SPEED = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_ATT   = 3'd1;
  localparam logic [REQ_W-1:0] REQ_PUSH_ALT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH_RANGE = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PUSH_FRAME = 3'd4;
  localparam logic [REQ_W-1:0] REQ_POP        = 3'd5;

  localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
  localparam logic [SRC_W-1:0] SRC_SONAR = 2'd1;
  localparam logic [SRC_W-1:0] SRC_ALT   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALT_FALLBACK = 2'd2;

  localparam logic [BOUND_W-1:0]    RANGE_LOW_RST  = 31'd26214;
  localparam logic [BOUND_W-1:0]    RANGE_HIGH_RST = 31'd393216;
  localparam logic [FALLBACK_W-1:0] FALLBACK_RST   = 16'd100;

  localparam logic signed [FRAME_RANGE_W-1:0] NO_RANGE = -32'sd65536;

  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_pop;
  } status_t;

endpackage
`default_nettype wire

// File: rtl/core/sensor_mailbox_range_tagger.sv
// a pop word is registered into the output after its input word is captured and its slot update state runs
// a new input word is taken only after the slot update for the last one is done (capture, then one slot update pass)
// a pop stalls in its update cycle while the previous output word is not taken
// reset: asynchronous active low; slots empty, held range and altitude cleared,
// config registers at their defaults
`default_nettype none
module sensor_mailbox_range_tagger
  import smrt_pkg::*;
#(
  parameter int TIME_WIDTH  = 40,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]         cfg_data_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [REQ_W-1:0]              req_type_i,
  input  wire logic [TIME_WIDTH-1:0]         time_ms_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_a_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_b_i,
  input  wire logic signed [VALUE_WIDTH-1:0] value_c_i,
  input  wire logic [FRAME_ID_W-1:0]         frame_id_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [KIND_W-1:0]                  kind_o,
  output logic [TIME_WIDTH-1:0]              sample_time_o,
  output logic signed [VALUE_WIDTH-1:0]      out_a_o,
  output logic signed [VALUE_WIDTH-1:0]      out_b_o,
  output logic signed [VALUE_WIDTH-1:0]      out_c_o,
  output logic [FRAME_ID_W-1:0]              out_frame_id_o,
  output logic signed [FRAME_RANGE_W-1:0]    frame_range_o,
  output logic [SRC_W-1:0]                   range_source_o
);

  cmd_t    cmd;
  status_t status;

  smrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  smrt_datapath #(
    .TIME_WIDTH  (TIME_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_type_i     (req_type_i),
    .time_ms_i      (time_ms_i),
    .value_a_i      (value_a_i),
    .value_b_i      (value_b_i),
    .value_c_i      (value_c_i),
    .frame_id_i     (frame_id_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .kind_o         (kind_o),
    .sample_time_o  (sample_time_o),
    .out_a_o        (out_a_o),
    .out_b_o        (out_b_o),
    .out_c_o        (out_c_o),
    .out_frame_id_o (out_frame_id_o),
    .frame_range_o  (frame_range_o),
    .range_source_o (range_source_o)
  );

endmodule
`default_nettype wire

// File: rtl/core/smrt_ctrl.sv
`default_nettype none
`include "sensor_mailbox_range_tagger_defines.svh"
module smrt_ctrl
  import smrt_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  input  wire status_t status_i,
  output cmd_t         cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   can_finish;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // a pop waits until the output word is free or being taken
  assign can_finish = !(status_i.is_pop && out_valid_q && !out_ready_i);

  assign cmd_o.load = in_valid_i && in_ready_o;
  assign cmd_o.exec = (state_q == S_EXEC) && can_finish;
  assign cmd_o.emit = cmd_o.exec && status_i.is_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (cmd_o.load) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (can_finish) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `SMRT_ASSERT_NEXT(a_load_to_exec, clk_i, rst_ni, cmd_o.load, state_q == S_EXEC)
  `SMRT_ASSERT_NEXT(a_emit_shows, clk_i, rst_ni, cmd_o.emit, out_valid_q)
  `SMRT_ASSERT_NEXT(a_word_kept, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q)
  `SMRT_ASSERT_NEXT(a_pop_stalls, clk_i, rst_ni,
                    (state_q == S_EXEC) && status_i.is_pop && out_valid_q && !out_ready_i,
                    state_q == S_EXEC)

endmodule
`default_nettype wire

// File: rtl/core/smrt_datapath.sv
`default_nettype none
module smrt_datapath
  import smrt_pkg::*;
#(
  parameter int TIME_WIDTH  = 40,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]            cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0]           cfg_data_i,
  input  wire logic [REQ_W-1:0]                req_type_i,
  input  wire logic [TIME_WIDTH-1:0]           time_ms_i,
  input  wire logic signed [VALUE_WIDTH-1:0]   value_a_i,
  input  wire logic signed [VALUE_WIDTH-1:0]   value_b_i,
  input  wire logic signed [VALUE_WIDTH-1:0]   value_c_i,
  input  wire logic [FRAME_ID_W-1:0]           frame_id_i,
  input  wire cmd_t                            cmd_i,
  output status_t                              status_o,
  output logic [KIND_W-1:0]                    kind_o,
  output logic [TIME_WIDTH-1:0]                sample_time_o,
  output logic signed [VALUE_WIDTH-1:0]        out_a_o,
  output logic signed [VALUE_WIDTH-1:0]        out_b_o,
  output logic signed [VALUE_WIDTH-1:0]        out_c_o,
  output logic [FRAME_ID_W-1:0]                out_frame_id_o,
  output logic signed [FRAME_RANGE_W-1:0]      frame_range_o,
  output logic [SRC_W-1:0]                     range_source_o
);

  localparam int TW    = TIME_WIDTH;
  localparam int VW    = VALUE_WIDTH;
  localparam int CMP_W = ((VW > BOUND_W) ? VW : BOUND_W) + 1;

  function automatic logic [VW-1:0] neg_sat(input logic [VW-1:0] v);
    logic [VW-1:0] min_v;
    min_v = {1'b1, {(VW-1){1'b0}}};
    if (v == min_v) begin
      return ~v;
    end
    return -v;
  endfunction

  // config registers
  logic [BOUND_W-1:0]    range_low_q, range_high_q;
  logic [FALLBACK_W-1:0] fallback_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_low_q  <= RANGE_LOW_RST;
      range_high_q <= RANGE_HIGH_RST;
      fallback_q   <= FALLBACK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RANGE_LOW:    range_low_q  <= cfg_data_i[BOUND_W-1:0];
        CFG_RANGE_HIGH:   range_high_q <= cfg_data_i[BOUND_W-1:0];
        CFG_ALT_FALLBACK: fallback_q   <= cfg_data_i[FALLBACK_W-1:0];
        default: ;
      endcase
    end
  end

  // request word
  logic [REQ_W-1:0]      req_q;
  logic [TW-1:0]         time_q;
  logic [VW-1:0]         a_q, b_q, c_q;
  logic [FRAME_ID_W-1:0] fid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q  <= req_type_i;
      time_q <= time_ms_i;
      a_q    <= value_a_i;
      b_q    <= value_b_i;
      c_q    <= value_c_i;
      fid_q  <= frame_id_i;
    end
  end

  logic is_push, is_pop;
  logic [KIND_W-1:0] new_kind;

  assign is_push    = (req_q <= REQ_PUSH_FRAME);
  assign is_pop     = (req_q == REQ_POP);
  assign new_kind   = req_q + KIND_W'(1);
  assign status_o.is_pop = is_pop;

  logic [VW-1:0]         new_a, new_b, new_c;
  logic [FRAME_ID_W-1:0] new_fid;

  always_comb begin
    new_a   = a_q;
    new_b   = '0;
    new_c   = '0;
    new_fid = '0;
    case (req_q) inside
      REQ_PUSH_SPEED: begin
        new_a = neg_sat(a_q);
        new_b = neg_sat(b_q);
        new_c = neg_sat(c_q);
      end
      REQ_PUSH_ATT: begin
        new_b = b_q;
        new_c = c_q;
      end
      REQ_PUSH_FRAME: begin
        new_a   = '0;
        new_fid = fid_q;
      end
      default: ;
    endcase
  end

  // slot store
  logic [KIND_W-1:0]     kind_q  [NUM_SLOTS];
  logic [TW-1:0]         stime_q [NUM_SLOTS];
  logic [VW-1:0]         sa_q    [NUM_SLOTS];
  logic [VW-1:0]         sb_q    [NUM_SLOTS];
  logic [VW-1:0]         sc_q    [NUM_SLOTS];
  logic [FRAME_ID_W-1:0] sfid_q  [NUM_SLOTS];
  logic [SLOT_CNT_W-1:0] count_q, count_after;

  logic                  found;
  logic [SLOT_IDX_W-1:0] found_idx;
  logic                  rm_en, append_en;
  logic [SLOT_IDX_W-1:0] rm_idx;

  always_comb begin
    found     = 1'b0;
    found_idx = '0;
    for (int j = NUM_SLOTS - 1; j >= 0; j--) begin
      if (kind_q[j] == new_kind) begin
        found     = 1'b1;
        found_idx = SLOT_IDX_W'(j);
      end
    end
  end

  assign rm_en       = is_pop ? (count_q != '0) : (is_push && found);
  assign rm_idx      = is_pop ? '0 : found_idx;
  assign count_after = count_q - SLOT_CNT_W'(rm_en);
  assign append_en   = is_push && (count_after < SLOT_CNT_W'(NUM_SLOTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_after + SLOT_CNT_W'(append_en);
    end
  end

  for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_slot
    logic shift, put;
    assign shift = cmd_i.exec && rm_en && (SLOT_IDX_W'(g) >= rm_idx);
    assign put   = cmd_i.exec && append_en && (count_after == SLOT_CNT_W'(g));

    if (g < NUM_SLOTS - 1) begin : g_mid
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          kind_q[g] <= KIND_EMPTY;
        end else if (put) begin
          kind_q[g] <= new_kind;
        end else if (shift) begin
          kind_q[g] <= kind_q[g+1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (put) begin
          stime_q[g] <= time_q;
          sa_q[g]    <= new_a;
          sb_q[g]    <= new_b;
          sc_q[g]    <= new_c;
          sfid_q[g]  <= new_fid;
        end else if (shift) begin
          stime_q[g] <= stime_q[g+1];
          sa_q[g]    <= sa_q[g+1];
          sb_q[g]    <= sb_q[g+1];
          sc_q[g]    <= sc_q[g+1];
          sfid_q[g]  <= sfid_q[g+1];
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          kind_q[g] <= KIND_EMPTY;
        end else if (put) begin
          kind_q[g] <= new_kind;
        end else if (shift) begin
          kind_q[g] <= KIND_EMPTY;
        end
      end
      always_ff @(posedge clk_i) begin
        if (put) begin
          stime_q[g] <= time_q;
          sa_q[g]    <= new_a;
          sb_q[g]    <= new_b;
          sc_q[g]    <= new_c;
          sfid_q[g]  <= new_fid;
        end
      end
    end
  end

  // held range and altitude
  logic [VW-1:0] held_range_q, held_range_d, held_alt_q, held_alt_d;
  logic [TW-1:0] held_time_q, held_time_d;
  logic          range_fresh_q, range_fresh_d, alt_fresh_q, alt_fresh_d;
  logic signed [FRAME_RANGE_W-1:0] range_w, alt_w;

  if (VW >= FRAME_RANGE_W) begin : g_trunc
    assign range_w = held_range_q[FRAME_RANGE_W-1:0];
    assign alt_w   = held_alt_q[FRAME_RANGE_W-1:0];
  end else begin : g_sext
    assign range_w = {{(FRAME_RANGE_W-VW){held_range_q[VW-1]}}, held_range_q};
    assign alt_w   = {{(FRAME_RANGE_W-VW){held_alt_q[VW-1]}}, held_alt_q};
  end

  logic signed [CMP_W-1:0] head_ext, low_ext, high_ext;
  logic          in_window, alt_pos, late;
  logic [TW-1:0] dt;

  assign head_ext  = {{(CMP_W-VW){sa_q[0][VW-1]}}, sa_q[0]};
  assign low_ext   = {{(CMP_W-BOUND_W){1'b0}}, range_low_q};
  assign high_ext  = {{(CMP_W-BOUND_W){1'b0}}, range_high_q};
  assign in_window = (head_ext > low_ext) && (head_ext < high_ext);
  assign alt_pos   = !held_alt_q[VW-1] && (held_alt_q != '0);
  assign dt        = stime_q[0] - held_time_q;
  assign late      = (stime_q[0] > held_time_q) &&
                     (dt > {{(TW-FALLBACK_W){1'b0}}, fallback_q});

  logic [KIND_W-1:0]               res_kind;
  logic [TW-1:0]                   res_time;
  logic [VW-1:0]                   res_a, res_b, res_c;
  logic [FRAME_ID_W-1:0]           res_fid;
  logic signed [FRAME_RANGE_W-1:0] res_fr;
  logic [SRC_W-1:0]                res_src;

  always_comb begin
    res_kind      = KIND_EMPTY;
    res_time      = '0;
    res_a         = '0;
    res_b         = '0;
    res_c         = '0;
    res_fid       = '0;
    res_fr        = '0;
    res_src       = SRC_NONE;
    held_range_d  = held_range_q;
    held_time_d   = held_time_q;
    range_fresh_d = range_fresh_q;
    held_alt_d    = held_alt_q;
    alt_fresh_d   = alt_fresh_q;
    if (count_q != '0) begin
      res_kind = kind_q[0];
      res_time = stime_q[0];
      res_a    = sa_q[0];
      res_b    = sb_q[0];
      res_c    = sc_q[0];
      res_fid  = sfid_q[0];
      case (kind_q[0])
        KIND_ALT: begin
          held_alt_d  = sa_q[0];
          alt_fresh_d = 1'b1;
        end
        KIND_RANGE: begin
          if (in_window) begin
            held_range_d  = sa_q[0];
            held_time_d   = stime_q[0];
            range_fresh_d = 1'b1;
          end else begin
            res_kind = KIND_NULL;
          end
        end
        KIND_FRAME: begin
          res_fr = NO_RANGE;
          if (range_fresh_q) begin
            res_fr        = range_w;
            res_src       = SRC_SONAR;
            range_fresh_d = 1'b0;
          end
          if (alt_fresh_q && alt_pos && late) begin
            res_fr      = alt_w;
            res_src     = SRC_ALT;
            alt_fresh_d = 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_range_q  <= '0;
      held_time_q   <= '0;
      range_fresh_q <= 1'b0;
      held_alt_q    <= '0;
      alt_fresh_q   <= 1'b0;
    end else if (cmd_i.emit) begin
      held_range_q  <= held_range_d;
      held_time_q   <= held_time_d;
      range_fresh_q <= range_fresh_d;
      held_alt_q    <= held_alt_d;
      alt_fresh_q   <= alt_fresh_d;
    end
  end

  // output word
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_o         <= res_kind;
      sample_time_o  <= res_time;
      out_a_o        <= res_a;
      out_b_o        <= res_b;
      out_c_o        <= res_c;
      out_frame_id_o <= res_fid;
      frame_range_o  <= res_fr;
      range_source_o <= res_src;
    end
  end

endmodule
`default_nettype wire

// File: verif/testbench.sv
`default_nettype none
module testbench;
  import smrt_pkg::*;

  localparam int TIME_W = 40;
  localparam int VAL_W = 32;
  localparam int SETTLE_CYCLES = 4;
  localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;
  localparam logic [VAL_W-1:0] VAL_MIN = 32'h8000_0000;
  localparam logic [VAL_W-1:0] VAL_MAX = 32'h7fff_ffff;

  typedef struct packed {
    logic [REQ_W-1:0]      req;
    logic [TIME_W-1:0]     stamp;
    logic [VAL_W-1:0]      a;
    logic [VAL_W-1:0]      b;
    logic [VAL_W-1:0]      c;
    logic [FRAME_ID_W-1:0] fid;
  } sensor_word_t;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic [TIME_W-1:0]        stamp;
    logic [VAL_W-1:0]         a;
    logic [VAL_W-1:0]         b;
    logic [VAL_W-1:0]         c;
    logic [FRAME_ID_W-1:0]    fid;
    logic [FRAME_RANGE_W-1:0] fr;
    logic [SRC_W-1:0]         src;
  } pop_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic out_ready_i = 1'b0;
  sensor_word_t in_word = '0;
  logic in_ready_o;
  logic out_valid_o;
  logic [KIND_W-1:0] kind_o;
  logic [TIME_W-1:0] sample_time_o;
  logic [VAL_W-1:0] out_a_o;
  logic [VAL_W-1:0] out_b_o;
  logic [VAL_W-1:0] out_c_o;
  logic [FRAME_ID_W-1:0] out_frame_id_o;
  logic [FRAME_RANGE_W-1:0] frame_range_o;
  logic [SRC_W-1:0] range_source_o;

  sensor_mailbox_range_tagger #(
    .TIME_WIDTH (TIME_W),
    .VALUE_WIDTH(VAL_W)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .req_type_i    (in_word.req),
    .time_ms_i     (in_word.stamp),
    .value_a_i     (in_word.a),
    .value_b_i     (in_word.b),
    .value_c_i     (in_word.c),
    .frame_id_i    (in_word.fid),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .sample_time_o (sample_time_o),
    .out_a_o       (out_a_o),
    .out_b_o       (out_b_o),
    .out_c_o       (out_c_o),
    .out_frame_id_o(out_frame_id_o),
    .frame_range_o (frame_range_o),
    .range_source_o(range_source_o)
  );

  always #4 clk_i = ~clk_i;

  sensor_word_t words_to_send[$];
  pop_word_t expected_pops[$];
  pop_word_t mbox_slots[$];
  sensor_word_t next_word;
  logic word_taken = 1'b0;
  bit steady = 1'b0;
  int unsigned mismatches = 0;
  logic [TIME_W-1:0] now_ms = '0;

  // predictor state and register copies
  logic [BOUND_W-1:0] lim_low = RANGE_LOW_RST;
  logic [BOUND_W-1:0] lim_high = RANGE_HIGH_RST;
  logic [FALLBACK_W-1:0] fallback_ms = FALLBACK_RST;
  logic signed [VAL_W-1:0] held_range = '0;
  logic [TIME_W-1:0] held_range_time = '0;
  logic range_fresh = 1'b0;
  logic signed [VAL_W-1:0] held_alt = '0;
  logic alt_fresh = 1'b0;

  function automatic logic [VAL_W-1:0] negate_sat(input logic [VAL_W-1:0] v);
    if (v == VAL_MIN) return VAL_MAX;
    return -v;
  endfunction

  task automatic apply_to_mailbox(input sensor_word_t w);
    pop_word_t e;
    logic [KIND_W-1:0] k;
    e = '0;
    k = KIND_EMPTY;
    case (w.req)
      REQ_PUSH_SPEED: k = KIND_SPEED;
      REQ_PUSH_ATT:   k = KIND_ATT;
      REQ_PUSH_ALT:   k = KIND_ALT;
      REQ_PUSH_RANGE: k = KIND_RANGE;
      REQ_PUSH_FRAME: k = KIND_FRAME;
      default: ;
    endcase
    if (k != KIND_EMPTY) begin
      for (int i = 0; i < mbox_slots.size(); i++) begin
        if (mbox_slots[i].kind == k) begin
          mbox_slots.delete(i);
          break;
        end
      end
      e.kind = k;
      e.stamp = w.stamp;
      case (k)
        KIND_SPEED: begin
          e.a = negate_sat(w.a);
          e.b = negate_sat(w.b);
          e.c = negate_sat(w.c);
        end
        KIND_ATT: begin
          e.a = w.a;
          e.b = w.b;
          e.c = w.c;
        end
        KIND_FRAME: e.fid = w.fid;
        default: e.a = w.a;
      endcase
      if (mbox_slots.size() < NUM_SLOTS) mbox_slots = {mbox_slots, e};
    end else if (w.req == REQ_POP) begin
      if (mbox_slots.size() != 0) begin
        e = mbox_slots.pop_front();
        case (e.kind)
          KIND_ALT: begin
            held_alt = e.a;
            alt_fresh = 1'b1;
          end
          KIND_RANGE: begin
            if ($signed(e.a) > $signed({1'b0, lim_low}) &&
                $signed(e.a) < $signed({1'b0, lim_high})) begin
              held_range = e.a;
              held_range_time = e.stamp;
              range_fresh = 1'b1;
            end else begin
              e.kind = KIND_NULL;
            end
          end
          KIND_FRAME: begin
            e.fr = NO_RANGE;
            if (range_fresh) begin
              e.fr = held_range;
              e.src = SRC_SONAR;
              range_fresh = 1'b0;
            end
            // a fresh, positive altitude wins once the sonar is stale
            if (alt_fresh && held_alt > 0 && e.stamp > held_range_time &&
                e.stamp - held_range_time > fallback_ms) begin
              e.fr = held_alt;
              e.src = SRC_ALT;
              alt_fresh = 1'b0;
            end
          end
          default: ;
        endcase
      end
      expected_pops = {expected_pops, e};
    end
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t %s expected %h actual %h", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_pop;
    pop_word_t want;
    pop_word_t got;
    got = {kind_o, sample_time_o, out_a_o, out_b_o, out_c_o, out_frame_id_o,
           frame_range_o, range_source_o};
    if (expected_pops.size() == 0) begin
      $display("%0t unexpected word expected none actual kind %0d", $time, got.kind);
      mismatches++;
    end else begin
      want = expected_pops.pop_front();
      check_field("kind", want.kind, got.kind);
      check_field("sample_time", want.stamp, got.stamp);
      check_field("out_a", want.a, got.a);
      check_field("out_b", want.b, got.b);
      check_field("out_c", want.c, got.c);
      check_field("out_frame_id", want.fid, got.fid);
      check_field("frame_range", want.fr, got.fr);
      check_field("range_source", want.src, got.src);
    end
  endtask

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      word_taken <= in_valid_i && in_ready_o;
      if (out_valid_o && out_ready_i) compare_pop();
      if (in_valid_i && in_ready_o) apply_to_mailbox(in_word);
    end
  end

  // driver
  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_ready_i <= steady || ($urandom_range(99) >= 6);
      if (!in_valid_i || word_taken) begin
        if (words_to_send.size() != 0 && (steady || $urandom_range(99) >= 6)) begin
          next_word = words_to_send.pop_front();
          in_word <= next_word;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic queue_word(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] stamp,
                            input logic [VAL_W-1:0] a, input logic [VAL_W-1:0] b,
                            input logic [VAL_W-1:0] c, input logic [FRAME_ID_W-1:0] fid);
    sensor_word_t w;
    w = '{req, stamp, a, b, c, fid};
    words_to_send = {words_to_send, w};
  endtask

  task automatic wait_drained;
    while (words_to_send.size() != 0 || in_valid_i || expected_pops.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_RANGE_LOW:    lim_low = data;
      CFG_RANGE_HIGH:   lim_high = data;
      CFG_ALT_FALLBACK: fallback_ms = data[FALLBACK_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic random_phase(input int count);
    int made;
    int pick;
    sensor_word_t w;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(99);
      w.a = $urandom;
      w.b = $urandom;
      w.c = $urandom;
      w.fid = FRAME_ID_W'($urandom);
      if ($urandom_range(19) == 0) now_ms = TIME_W'({$urandom, $urandom});
      else now_ms = now_ms + $urandom_range(150);
      w.stamp = now_ms;
      if (pick < 4) begin
        w.req = REQ_W'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
      end else if (pick < 44) begin
        w.req = REQ_POP;
        made++;
      end else begin
        made++;
        case ($urandom_range(4))
          0: begin
            w.req = REQ_PUSH_SPEED;
            if ($urandom_range(4) == 0) w.a = VAL_MIN;
            if ($urandom_range(4) == 0) w.c = VAL_MAX;
          end
          1: w.req = REQ_PUSH_ATT;
          2: begin
            w.req = REQ_PUSH_ALT;
            if ($urandom_range(3) != 0) w.a = $urandom_range(32'h00ff_ffff, 1);
          end
          3: begin
            w.req = REQ_PUSH_RANGE;
            case ($urandom_range(4))
              0: w.a = lim_low + $urandom_range(2) - 1;
              1: w.a = lim_high + $urandom_range(2) - 1;
              2, 3: w.a = $urandom_range(lim_high, lim_low);
              default: ;
            endcase
          end
          default: w.req = REQ_PUSH_FRAME;
        endcase
      end
      words_to_send = {words_to_send, w};
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    queue_word(REQ_POP, '0, '0, '0, '0, '0);
    queue_word(REQ_PUSH_SPEED, '0, VAL_MIN, VAL_MAX, '0, '0);
    queue_word(REQ_POP, '0, '0, '0, '0, '0);
    queue_word(REQ_PUSH_ATT, 40'hff_ffff_ffff, 32'hffff_ffff, VAL_MIN, VAL_MAX, 16'hffff);
    queue_word(REQ_PUSH_ALT, 40'd20, 32'h0001_0000, 32'h1234_5678, 32'h9abc_def0, '0);
    queue_word(REQ_PUSH_RANGE, 40'd30, 32'(RANGE_LOW_RST), 32'hffff_ffff, '0, '0);
    queue_word(REQ_PUSH_FRAME, 40'd50, 32'h1111_1111, '1, '1, 16'hffff);
    repeat (4) queue_word(REQ_POP, '0, '0, '0, '0, '0);
    // window edges and the sonar tag right at the fallback time
    queue_word(REQ_PUSH_RANGE, 40'd1000, RANGE_LOW_RST + 1, '0, '0, '0);
    queue_word(REQ_PUSH_FRAME, 40'd1100, '0, '0, '0, '0);
    repeat (2) queue_word(REQ_POP, '0, '0, '0, '0, '0);
    queue_word(REQ_PUSH_RANGE, 40'hff_ffff_ffff, 32'(RANGE_HIGH_RST), '0, '0, '0);
    queue_word(REQ_PUSH_FRAME, 40'd1101, '0, '0, '0, 16'ha5a5);
    repeat (2) queue_word(REQ_POP, '0, '0, '0, '0, '0);
    queue_word(REQ_UNUSED_LO, 40'h55_5555_5555, VAL_MAX, VAL_MIN, '1, 16'h5555);
    queue_word(REQ_UNUSED_HI, 40'haa_aaaa_aaaa, VAL_MIN, VAL_MAX, '0, 16'haaaa);
    // altitude overrides a sonar tag on the same frame
    queue_word(REQ_PUSH_RANGE, 40'd1200, RANGE_HIGH_RST - 1, '0, '0, '0);
    queue_word(REQ_PUSH_ALT, 40'd0, VAL_MAX, '0, '0, '0);
    queue_word(REQ_PUSH_FRAME, 40'd1301, '0, '0, '0, 16'h5a5a);
    repeat (3) queue_word(REQ_POP, '0, '0, '0, '0, '0);
    now_ms = 40'd2000;
    random_phase(190);

    wait_drained();
    write_reg(CFG_RANGE_LOW, '0);
    write_reg(CFG_RANGE_HIGH, '1);
    write_reg(CFG_ALT_FALLBACK, '0);
    random_phase(190);

    wait_drained();
    write_reg(CFG_RANGE_LOW, '1);
    write_reg(CFG_ALT_FALLBACK, 31'(16'hffff));
    steady = 1'b1;
    random_phase(190);

    wait_drained();
    steady = 1'b0;
    write_reg(CFG_RANGE_LOW, 31'($urandom_range(32'h0001_0000)));
    write_reg(CFG_RANGE_HIGH, 31'($urandom_range(32'h0010_0000, 32'h0002_0000)));
    write_reg(CFG_ALT_FALLBACK, 31'($urandom_range(500)));
    random_phase(190);

    wait_drained();
    write_reg(CFG_RANGE_LOW, 31'(RANGE_LOW_RST));
    write_reg(CFG_RANGE_HIGH, 31'(RANGE_HIGH_RST));
    write_reg(CFG_ALT_FALLBACK, 31'(FALLBACK_RST));
    random_phase(190);

    wait_drained();
    if (mismatches == 0 && expected_pops.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/smrt_pkg.sv
rtl/core/smrt_ctrl.sv
rtl/core/smrt_datapath.sv
rtl/core/sensor_mailbox_range_tagger.sv
verif/testbench.sv
